FILE: sv/otpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otpe_pkg
// Shared types, byte codes and segment tables for the overstrike converter.
// ----------------------------------------------------------------------------
package otpe_pkg;

  localparam int INDENT_MAX = 31;
  localparam int OUT_CAP    = 40;
  localparam int OCNT_W     = $clog2(OUT_CAP + 1);
  localparam int ADDR_W     = 5;
  localparam int NUM_SEG    = 15;

  localparam logic [7:0] BY_ESC        = 8'h1B;
  localparam logic [7:0] BY_NL         = 8'h0A;
  localparam logic [7:0] BY_FF         = 8'h0C;
  localparam logic [7:0] BY_BS         = 8'h08;
  localparam logic [7:0] BY_UNDERSCORE = 8'h5F;
  localparam logic [7:0] BY_SPACE      = 8'h20;
  localparam logic [7:0] BY_COMP_ON    = 8'h0F;
  localparam logic [7:0] BY_COMP_OFF   = 8'h92;
  localparam logic [7:0] BY_WIDE_ON    = 8'h0E;
  localparam logic [7:0] BY_WIDE_OFF   = 8'h94;
  localparam logic [7:0] BY_ITALIC     = 8'h80;
  localparam logic [7:0] CH_AT         = 8'h40;
  localparam logic [7:0] CH_E          = 8'h45;
  localparam logic [7:0] CH_F          = 8'h46;
  localparam logic [7:0] CH_0          = 8'h30;
  localparam logic [7:0] CH_2          = 8'h32;
  localparam logic [7:0] CH_C          = 8'h43;
  localparam logic [7:0] CH_X          = 8'h58;
  localparam logic [7:0] CH_B          = 8'h42;

  typedef enum logic [1:0] {OP_DATA, OP_EOF, OP_START, OP_END} op_t;

  typedef enum logic [1:0] {PH_NONE, PH_HELD, PH_ITALIC, PH_EMPH} phase_t;

  typedef enum logic [2:0] {
    REG_INDENT, REG_LINE_REPEAT, REG_WIDE, REG_ROMAN,
    REG_DSB, REG_FF_END, REG_COMPRESSED, REG_EIGHT_LPI
  } reg_t;

  // Output segments in the order they go out within one item
  typedef enum logic [3:0] {
    SEG_HELD, SEG_BS, SEG_ITAL, SEG_EMPH, SEG_INIT, SEG_COMP_ON, SEG_LPI_ON,
    SEG_COMP_OFF, SEG_LPI_OFF, SEG_WIDE_OFF, SEG_RESET, SEG_NL, SEG_FF,
    SEG_WIDE_ON, SEG_SPACE
  } seg_t;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  typedef struct packed {
    logic [4:0] indent_count;
    logic [1:0] line_repeat;
    logic       wide_mode;
    logic       roman_mode;
    logic       double_strike_bold;
    logic       form_feed_at_end;
    logic       compressed_mode;
    logic       eight_lpi;
    logic [4:0] spaces;
  } cfg_t;

  typedef struct packed {
    logic [NUM_SEG-1:0] mask;
    logic [7:0]         held;
    logic [7:0]         ital;
  } plan_t;

  function automatic logic [NUM_SEG-1:0] seg_bit(seg_t s);
    seg_bit = NUM_SEG'(1) << s;
  endfunction

  function automatic logic [7:0] seg_byte(seg_t s, logic [4:0] k, logic [7:0] held,
                                          logic [7:0] ital);
    logic [7:0] b;
    b = BY_SPACE;
    case (s)
      SEG_HELD:     b = held;
      SEG_BS:       b = BY_BS;
      SEG_ITAL:     b = ital;
      SEG_EMPH: begin
        case (k[2:0])
          3'd0:    b = BY_ESC;
          3'd1:    b = CH_E;
          3'd2:    b = held;
          3'd3:    b = BY_ESC;
          default: b = CH_F;
        endcase
      end
      SEG_INIT,
      SEG_RESET:    b = k[0] ? CH_AT : BY_ESC;
      SEG_COMP_ON:  b = BY_COMP_ON;
      SEG_LPI_ON: begin
        case (k[2:0])
          3'd0:    b = BY_ESC;
          3'd1:    b = CH_0;
          3'd2:    b = BY_ESC;
          3'd3:    b = CH_C;
          default: b = CH_X;
        endcase
      end
      SEG_COMP_OFF: b = BY_COMP_OFF;
      SEG_LPI_OFF: begin
        case (k[2:0])
          3'd0:    b = BY_ESC;
          3'd1:    b = CH_2;
          3'd2:    b = BY_ESC;
          3'd3:    b = CH_C;
          default: b = CH_B;
        endcase
      end
      SEG_WIDE_OFF: b = BY_WIDE_OFF;
      SEG_NL:       b = BY_NL;
      SEG_FF:       b = BY_FF;
      SEG_WIDE_ON:  b = BY_WIDE_ON;
      default:      b = BY_SPACE;
    endcase
    seg_byte = b;
  endfunction

  // Index of the final byte of a segment
  function automatic logic [4:0] seg_last_idx(seg_t s, logic [1:0] line_repeat,
                                              logic [4:0] spaces);
    logic [4:0] n;
    n = 5'd0;
    case (s)
      SEG_EMPH, SEG_LPI_ON, SEG_LPI_OFF: n = 5'd4;
      SEG_INIT, SEG_RESET:               n = 5'd1;
      SEG_NL:                            n = 5'({3'd0, line_repeat} - 5'd1);
      SEG_SPACE:                         n = spaces - 5'd1;
      default:                           n = 5'd0;
    endcase
    seg_last_idx = n;
  endfunction

endpackage

FILE: sv/otpe_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otpe_in_if / otpe_out_if
// Valid/ready channels for text input words and printer output words.
// ----------------------------------------------------------------------------
interface otpe_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] in_byte;

  modport source (output valid, output operation, output in_byte, input ready);
  modport sink (input valid, input operation, input in_byte, output ready);
endinterface

interface otpe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface

FILE: sv/otpe_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otpe_cfg
// APB register file for the converter options.
// ----------------------------------------------------------------------------
module otpe_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [otpe_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output otpe_pkg::cfg_t              cfg
);
  import otpe_pkg::*;

  logic [4:0] indent_count;
  logic [1:0] line_repeat;
  logic       wide_mode;
  logic       roman_mode;
  logic       double_strike_bold;
  logic       form_feed_at_end;
  logic       compressed_mode;
  logic       eight_lpi;
  logic       wr;
  reg_t       idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      indent_count       <= 5'd0;
      line_repeat        <= 2'd1;
      wide_mode          <= 1'b0;
      roman_mode         <= 1'b0;
      double_strike_bold <= 1'b0;
      form_feed_at_end   <= 1'b1;
      compressed_mode    <= 1'b0;
      eight_lpi          <= 1'b0;
    end else if (wr) begin
      case (idx)
        REG_INDENT:      indent_count       <= pwdata[4:0];
        REG_LINE_REPEAT: line_repeat        <= pwdata[1:0];
        REG_WIDE:        wide_mode          <= pwdata[0];
        REG_ROMAN:       roman_mode         <= pwdata[0];
        REG_DSB:         double_strike_bold <= pwdata[0];
        REG_FF_END:      form_feed_at_end   <= pwdata[0];
        REG_COMPRESSED:  compressed_mode    <= pwdata[0];
        REG_EIGHT_LPI:   eight_lpi          <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_INDENT:      prdata = {27'd0, indent_count};
      REG_LINE_REPEAT: prdata = {30'd0, line_repeat};
      REG_WIDE:        prdata = {31'd0, wide_mode};
      REG_ROMAN:       prdata = {31'd0, roman_mode};
      REG_DSB:         prdata = {31'd0, double_strike_bold};
      REG_FF_END:      prdata = {31'd0, form_feed_at_end};
      REG_COMPRESSED:  prdata = {31'd0, compressed_mode};
      REG_EIGHT_LPI:   prdata = {31'd0, eight_lpi};
      default:         prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg.indent_count       = indent_count;
    cfg.line_repeat        = line_repeat;
    cfg.wide_mode          = wide_mode;
    cfg.roman_mode         = roman_mode;
    cfg.double_strike_bold = double_strike_bold;
    cfg.form_feed_at_end   = form_feed_at_end;
    cfg.compressed_mode    = compressed_mode;
    cfg.eight_lpi          = eight_lpi;
    // clamp the indent run
    cfg.spaces = (32'(indent_count) > INDENT_MAX) ? 5'(INDENT_MAX) : indent_count;
  end

endmodule

FILE: sv/otpe_plan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otpe_plan
// Overstrike tracker: holds the pending character and decides which output
// segments an accepted word produces.
// ----------------------------------------------------------------------------
module otpe_plan (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [1:0]          operation,
  input  logic [7:0]          in_byte,
  input  otpe_pkg::cfg_t      cfg,
  output otpe_pkg::plan_t     plan
);
  import otpe_pkg::*;

  logic [7:0]         held_char;
  logic [7:0]         held_char_next;
  phase_t             phase;
  phase_t             phase_next;
  logic [NUM_SEG-1:0] mask;
  logic [NUM_SEG-1:0] indent_mask;
  logic [NUM_SEG-1:0] flush_mask;
  logic [NUM_SEG-1:0] fresh_mask;
  phase_t             fresh_phase;
  logic [7:0]         fresh_held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_char <= 8'd0;
      phase     <= PH_NONE;
    end else if (accept) begin
      held_char <= held_char_next;
      phase     <= phase_next;
    end
  end

  always_comb begin
    indent_mask = (cfg.wide_mode ? seg_bit(SEG_WIDE_ON) : '0)
                | ((cfg.spaces != 5'd0) ? seg_bit(SEG_SPACE) : '0);

    flush_mask = '0;
    if (phase == PH_HELD) flush_mask = seg_bit(SEG_HELD);
    if (phase == PH_EMPH) flush_mask = seg_bit(SEG_HELD) | seg_bit(SEG_BS);

    // a byte taken as the start of a new character
    fresh_mask  = '0;
    fresh_phase = PH_HELD;
    fresh_held  = in_byte;
    if (in_byte == BY_NL) begin
      fresh_mask  = ((cfg.line_repeat != 2'd0) ? seg_bit(SEG_NL) : '0) | indent_mask;
      fresh_phase = PH_NONE;
      fresh_held  = held_char;
    end else if (in_byte == BY_FF) begin
      fresh_mask  = seg_bit(SEG_FF) | indent_mask;
      fresh_phase = PH_NONE;
      fresh_held  = held_char;
    end

    mask           = '0;
    phase_next     = PH_NONE;
    held_char_next = held_char;
    case (op_t'(operation))
      OP_DATA: begin
        case (phase)
          PH_NONE: begin
            mask           = fresh_mask;
            phase_next     = fresh_phase;
            held_char_next = fresh_held;
          end
          PH_HELD: begin
            if (in_byte == BY_BS && held_char == BY_UNDERSCORE && !cfg.roman_mode) begin
              phase_next = PH_ITALIC;
            end else if (in_byte == BY_BS && !cfg.double_strike_bold) begin
              phase_next = PH_EMPH;
            end else begin
              mask           = seg_bit(SEG_HELD) | fresh_mask;
              phase_next     = fresh_phase;
              held_char_next = fresh_held;
            end
          end
          PH_ITALIC: begin
            mask = seg_bit(SEG_ITAL);
          end
          default: begin
            if (in_byte == held_char) begin
              mask = seg_bit(SEG_EMPH);
            end else begin
              mask           = seg_bit(SEG_HELD) | seg_bit(SEG_BS) | fresh_mask;
              phase_next     = fresh_phase;
              held_char_next = fresh_held;
            end
          end
        endcase
      end
      OP_EOF: begin
        mask = flush_mask
             | (cfg.form_feed_at_end ? (seg_bit(SEG_FF) | indent_mask) : '0);
      end
      OP_START: begin
        mask = seg_bit(SEG_INIT)
             | (cfg.compressed_mode ? seg_bit(SEG_COMP_ON) : '0)
             | (cfg.eight_lpi ? seg_bit(SEG_LPI_ON) : '0)
             | indent_mask;
      end
      default: begin
        mask = flush_mask
             | (cfg.compressed_mode ? seg_bit(SEG_COMP_OFF) : '0)
             | (cfg.eight_lpi ? seg_bit(SEG_LPI_OFF) : '0)
             | (cfg.wide_mode ? seg_bit(SEG_WIDE_OFF) : '0)
             | seg_bit(SEG_RESET);
      end
    endcase

    plan.mask = mask;
    plan.held = held_char;
    plan.ital = in_byte + BY_ITALIC;
  end

endmodule

FILE: sv/otpe_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otpe_seq
// Byte sequencer: walks pending segments one byte per cycle while the sink is
// ready, via a shared index counter and table lookup into the output register.
// ----------------------------------------------------------------------------
module otpe_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  otpe_pkg::plan_t plan,
  input  otpe_pkg::cfg_t  cfg,
  output logic            idle,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last
);
  import otpe_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [NUM_SEG-1:0] mask;
  logic [NUM_SEG-1:0] mask_next;
  logic [4:0]         rep;
  logic [4:0]         rep_next;
  logic [OCNT_W-1:0]  ocnt;
  logic [OCNT_W-1:0]  ocnt_next;
  logic [7:0]         held;
  logic [7:0]         ital;
  logic               out_valid_next;
  logic [7:0]         out_byte_next;
  logic               out_last_next;
  seg_t               cur;
  logic [NUM_SEG-1:0] mask_rest;
  logic               seg_done;
  logic               fin;
  logic               fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      mask      <= '0;
      rep       <= 5'd0;
      ocnt      <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      mask      <= mask_next;
      rep       <= rep_next;
      ocnt      <= ocnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= plan.held;
      ital <= plan.ital;
    end
    out_byte <= out_byte_next;
    out_last <= out_last_next;
  end

  always_comb begin
    // lowest pending segment goes first
    cur = SEG_HELD;
    for (int i = NUM_SEG - 1; i >= 0; i--) begin
      if (mask[i]) cur = seg_t'(4'(i));
    end
    mask_rest = mask & ~seg_bit(cur);
    seg_done  = (rep == seg_last_idx(cur, cfg.line_repeat, cfg.spaces));
    // drop whatever lies past the output cap
    fin       = (seg_done && mask_rest == '0) || (ocnt == OCNT_W'(OUT_CAP - 1));
    fire      = (state == ST_RUN) && (!out_valid || out_ready);
    idle      = (state == ST_IDLE);

    state_next     = state;
    mask_next      = mask;
    rep_next       = rep;
    ocnt_next      = ocnt;
    out_valid_next = out_valid && !out_ready;
    out_byte_next  = out_byte;
    out_last_next  = out_last;

    case (state)
      ST_IDLE: begin
        if (accept && plan.mask != '0) begin
          state_next = ST_RUN;
          mask_next  = plan.mask;
          rep_next   = 5'd0;
          ocnt_next  = '0;
        end
      end
      default: begin
        if (fire) begin
          out_valid_next = 1'b1;
          out_byte_next  = seg_byte(cur, rep, held, ital);
          out_last_next  = fin;
          ocnt_next      = ocnt + OCNT_W'(1);
          if (fin) begin
            state_next = ST_IDLE;
            mask_next  = '0;
          end else if (seg_done) begin
            mask_next = mask_rest;
            rep_next  = 5'd0;
          end else begin
            rep_next = rep + 5'd1;
          end
        end
      end
    endcase
  end

endmodule

FILE: sv/overstrike_to_printer_escapes.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overstrike_to_printer_escapes
// Converts typewriter overstrike text into dot-matrix printer bytes.
// ----------------------------------------------------------------------------
// Flow: an accepted text word sets the sequencer state register to run, then
// the first printer word goes into the output register, and the byte sequencer
// emits the rest one word per cycle while the sink is ready. An item gives N
// output words (N up to 40); no new text word is taken until the sequencer has
// issued the last of them. Items with no output leave the input ready.
// Reset (rst, synchronous): registers to defaults, tracker empty, output empty.
module overstrike_to_printer_escapes (
  input  logic                        clk,
  input  logic                        rst,
  otpe_in_if.sink                     text,
  otpe_out_if.source                  printer,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [otpe_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import otpe_pkg::*;

  cfg_t  cfg;
  plan_t plan;
  logic  idle;
  logic  accept;

  assign text.ready = idle;
  assign accept     = text.valid && idle;

  otpe_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  otpe_plan u_plan (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (text.operation),
    .in_byte   (text.in_byte),
    .cfg       (cfg),
    .plan      (plan)
  );

  otpe_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .plan      (plan),
    .cfg       (cfg),
    .idle      (idle),
    .out_valid (printer.valid),
    .out_ready (printer.ready),
    .out_byte  (printer.out_byte),
    .out_last  (printer.last)
  );

endmodule

FILE: sv/otpe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otpe_checker
// Port-level checks for the overstrike converter, bound to the top level.
// ----------------------------------------------------------------------------
module otpe_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [7:0]                  out_byte,
  input logic                        out_last,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [otpe_pkg::ADDR_W-1:0] paddr,
  input logic [31:0]                 pwdata,
  input logic [31:0]                 prdata
);
  import otpe_pkg::*;

  // no new text word while a run is still going out
  a_busy_mid_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> !in_ready)
    else $error("input ready in the middle of an output run");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(out_last)))
    else $error("stalled printer word changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("printer word valid after reset");

  a_indent_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_INDENT)
      ##1 (paddr[ADDR_W-1:2] == REG_INDENT)
      |-> (prdata[4:0] == $past(pwdata[4:0])))
    else $error("indent register readback mismatch");

endmodule

bind overstrike_to_printer_escapes otpe_checker u_otpe_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (text.ready),
  .out_valid (printer.valid),
  .out_ready (printer.ready),
  .out_byte  (printer.out_byte),
  .out_last  (printer.last),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);
